// ===== src/fab_pkg.sv =====
package fab_pkg;

    // Frame geometry
    localparam int POINTS   = 1024;
    localparam int IDX_W    = (POINTS > 1) ? $clog2(POINTS) : 1;

    // Field widths
    localparam int FUNC_W   = 2;
    localparam int PIDX_W   = 10;
    localparam int X_W      = 16;
    localparam int SAMPLE_W = 16;
    localparam int DIFF_W   = SAMPLE_W + 2;
    localparam int VAL_W    = 40;
    localparam int CNT_W    = 16;
    localparam int DIVR_W   = CNT_W + 1;

    // Register port
    localparam int PADDR_W  = 4;
    localparam int PDATA_W  = 32;

    // Input item kinds
    localparam logic [FUNC_W-1:0] FUNC_SAMPLE  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_LOAD    = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR   = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_RESTART = 2'd3;

    // Modes
    localparam logic [1:0] MODE_PASS = 2'd0;
    localparam logic [1:0] MODE_ACC  = 2'd1;
    localparam logic [1:0] MODE_BASE = 2'd2;

    // Register indexes (word address)
    localparam logic [1:0] REG_MODE   = 2'd0;
    localparam logic [1:0] REG_TARGET = 2'd1;
    localparam logic [1:0] REG_DIV_EN = 2'd2;

    // Request to the point stores
    typedef struct packed {
        logic                       rd_en;
        logic                       base_we;
        logic                       sum_we;
        logic [IDX_W-1:0]           addr;
        logic signed [SAMPLE_W-1:0] base_wdata;
        logic signed [VAL_W-1:0]    sum_wdata;
    } t_store_req;

    // Point index folded onto the store depth
    function automatic logic [IDX_W-1:0] to_idx(input logic [PIDX_W-1:0] pidx);
        logic [31:0] t;
        t = 32'(pidx) % POINTS;
        return t[IDX_W-1:0];
    endfunction

endpackage

// ===== src/frame_accumulate_baseline_top.sv =====
// A sample request goes through sum memory read at accept, update/write-back and output
//   load; a divided result also passes the 1-bit-per-cycle divider before output load.
//   No new request is accepted until the last one is done, and a stalled output holds it.
// Load, clear and restart requests give no result.
// Reset (synchronous, active low) clears control state, baseline valid and frame count;
//   memory contents stay. The user must read only written entries; this is not checked.
module frame_accumulate_baseline_top (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // Input channel
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic [fab_pkg::FUNC_W-1:0]           i_func,
    input  logic [fab_pkg::PIDX_W-1:0]           i_point_index,
    input  logic [fab_pkg::X_W-1:0]              i_x_coord,
    input  logic signed [fab_pkg::SAMPLE_W-1:0]  i_sample_value,
    input  logic                                 i_frame_last,
    // Output channel
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic [fab_pkg::PIDX_W-1:0]           o_out_index,
    output logic [fab_pkg::X_W-1:0]              o_out_x,
    output logic signed [fab_pkg::VAL_W-1:0]     o_out_value,
    output logic                                 o_out_last,
    // Register port
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [fab_pkg::PADDR_W-1:0]          paddr,
    input  logic [fab_pkg::PDATA_W-1:0]          pwdata,
    output logic [fab_pkg::PDATA_W-1:0]          prdata,
    output logic                                 pready
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CALC = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;
    localparam logic [1:0] S_OUT  = 2'd3;

    localparam logic [fab_pkg::CNT_W-1:0] CNT_MAX = '1;

    // Control state
    logic [1:0]                      r_state;
    logic [1:0]                      r_mode;
    logic [fab_pkg::CNT_W-1:0]       r_target;
    logic                            r_div_en;
    logic                            r_bvalid;
    logic [fab_pkg::CNT_W-1:0]       r_frames;
    logic                            r_fresh;
    logic                            r_out_valid;

    // Item and result registers
    logic [fab_pkg::IDX_W-1:0]       r_idx;
    logic [fab_pkg::PIDX_W-1:0]      r_pidx;
    logic [fab_pkg::X_W-1:0]         r_x;
    logic signed [fab_pkg::SAMPLE_W-1:0] r_sample;
    logic                            r_last;
    logic signed [fab_pkg::VAL_W-1:0] r_res;
    logic [fab_pkg::PIDX_W-1:0]      r_out_index;
    logic [fab_pkg::X_W-1:0]         r_out_x;
    logic signed [fab_pkg::VAL_W-1:0] r_out_value;
    logic                            r_out_last;

    logic                            in_fire;
    logic                            cfg_wr;
    logic                            out_free;
    fab_pkg::t_store_req             store_req;
    logic signed [fab_pkg::SAMPLE_W-1:0] base_rd;
    logic signed [fab_pkg::VAL_W-1:0] sum_rd;

    logic signed [fab_pkg::DIFF_W-1:0] c_base;
    logic signed [fab_pkg::DIFF_W-1:0] c_diff;
    logic signed [fab_pkg::VAL_W-1:0]  c_prev;
    logic signed [fab_pkg::VAL_W:0]    c_sum;
    logic signed [fab_pkg::VAL_W-1:0]  c_sat;
    logic [fab_pkg::DIVR_W-1:0]        c_cur;
    logic                              c_due;
    logic                              div_start;
    logic                              div_done;
    logic signed [fab_pkg::VAL_W-1:0]  div_quot;

    assign in_fire    = i_in_valid && o_in_ready;
    assign o_in_ready = (r_state == S_IDLE);
    assign cfg_wr     = psel && penable && pwrite && pready;
    assign pready     = 1'b1;
    assign out_free   = !r_out_valid || i_out_ready;

    // Register read-back
    always_comb begin
        case (paddr[3:2])
            fab_pkg::REG_MODE:   prdata = {30'd0, r_mode};
            fab_pkg::REG_TARGET: prdata = {16'd0, r_target};
            fab_pkg::REG_DIV_EN: prdata = {31'd0, r_div_en};
            default:             prdata = '0;
        endcase
    end

    // Sum update: difference to baseline, accumulate, saturate
    always_comb begin
        c_base = r_bvalid ? fab_pkg::DIFF_W'(base_rd) : '0;
        c_diff = fab_pkg::DIFF_W'(r_sample) - c_base;
        c_prev = r_fresh ? '0 : sum_rd;
        c_sum  = (fab_pkg::VAL_W+1)'(c_prev) + (fab_pkg::VAL_W+1)'(c_diff);
        if (c_sum[fab_pkg::VAL_W] != c_sum[fab_pkg::VAL_W-1]) begin
            c_sat = c_sum[fab_pkg::VAL_W] ? {1'b1, {(fab_pkg::VAL_W-1){1'b0}}}
                                          : {1'b0, {(fab_pkg::VAL_W-1){1'b1}}};
        end else begin
            c_sat = c_sum[fab_pkg::VAL_W-1:0];
        end
        c_cur = {1'b0, r_frames} + 1'b1;
        c_due = (r_target == '0) || (c_cur >= {1'b0, r_target});
    end

    assign div_start = (r_state == S_CALC) && (r_mode == fab_pkg::MODE_ACC) &&
                       (r_target != '0) && c_due && r_div_en;

    // Store requests: read and baseline write at accept, sum write-back in calc
    always_comb begin
        store_req.rd_en      = in_fire && (i_func == fab_pkg::FUNC_SAMPLE);
        store_req.base_we    = in_fire && (i_func == fab_pkg::FUNC_LOAD);
        store_req.sum_we     = (r_state == S_CALC) && (r_mode == fab_pkg::MODE_ACC);
        store_req.addr       = (r_state == S_IDLE) ? fab_pkg::to_idx(i_point_index) : r_idx;
        store_req.base_wdata = i_sample_value;
        store_req.sum_wdata  = c_sat;
    end

    fab_store u_store (
        .i_clk     (i_clk),
        .i_req     (store_req),
        .o_base_rd (base_rd),
        .o_sum_rd  (sum_rd)
    );

    fab_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (c_sat),
        .i_divisor  (c_cur),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    // Sequencer, configuration and frame bookkeeping
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_mode      <= fab_pkg::MODE_PASS;
            r_target    <= '0;
            r_div_en    <= 1'b0;
            r_bvalid    <= 1'b0;
            r_frames    <= '0;
            r_fresh     <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            // configuration writes
            if (cfg_wr) begin
                case (paddr[3:2])
                    fab_pkg::REG_MODE: begin
                        if (pwdata[1:0] == fab_pkg::MODE_ACC && r_mode != fab_pkg::MODE_ACC) begin
                            r_frames <= '0;
                            r_fresh  <= 1'b1;
                        end
                        r_mode <= pwdata[1:0];
                    end
                    fab_pkg::REG_TARGET: r_target <= pwdata[fab_pkg::CNT_W-1:0];
                    fab_pkg::REG_DIV_EN: r_div_en <= pwdata[0];
                    default: ;
                endcase
            end

            // output register
            if (r_state == S_OUT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (in_fire) begin
                        case (i_func)
                            fab_pkg::FUNC_SAMPLE: r_state <= S_CALC;
                            fab_pkg::FUNC_LOAD:   r_bvalid <= 1'b1;
                            fab_pkg::FUNC_CLEAR:  r_bvalid <= 1'b0;
                            fab_pkg::FUNC_RESTART: begin
                                r_frames <= '0;
                                r_fresh  <= 1'b1;
                            end
                            default: ;
                        endcase
                    end
                end
                S_CALC: begin
                    case (r_mode)
                        fab_pkg::MODE_ACC: begin
                            if (r_target == '0) begin
                                // running sums every frame
                                if (r_last) begin
                                    r_frames <= c_cur[fab_pkg::CNT_W] ? CNT_MAX
                                                                      : c_cur[fab_pkg::CNT_W-1:0];
                                    r_fresh  <= 1'b0;
                                end
                                r_state <= S_OUT;
                            end else if (c_due) begin
                                // final frame: emit and restart at its end
                                if (r_last) begin
                                    r_frames <= '0;
                                    r_fresh  <= 1'b1;
                                end
                                r_state <= r_div_en ? S_DIV : S_OUT;
                            end else begin
                                // intermediate frame, no result
                                if (r_last) begin
                                    r_frames <= c_cur[fab_pkg::CNT_W-1:0];
                                    r_fresh  <= 1'b0;
                                end
                                r_state <= S_IDLE;
                            end
                        end
                        default: r_state <= S_OUT;
                    endcase
                end
                S_DIV: begin
                    if (div_done) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Item capture, result and output payload
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_idx    <= fab_pkg::to_idx(i_point_index);
            r_pidx   <= i_point_index;
            r_x      <= i_x_coord;
            r_sample <= i_sample_value;
            r_last   <= i_frame_last;
        end
        if (r_state == S_CALC) begin
            case (r_mode)
                fab_pkg::MODE_ACC:  r_res <= c_sat;
                fab_pkg::MODE_BASE: r_res <= fab_pkg::VAL_W'(c_diff);
                default:            r_res <= fab_pkg::VAL_W'(r_sample);
            endcase
        end else if (r_state == S_DIV && div_done) begin
            r_res <= div_quot;
        end
        if (r_state == S_OUT && out_free) begin
            r_out_index <= r_pidx;
            r_out_x     <= r_x;
            r_out_value <= r_res;
            r_out_last  <= r_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_index = r_out_index;
    assign o_out_x     = r_out_x;
    assign o_out_value = r_out_value;
    assign o_out_last  = r_out_last;

endmodule

// ===== src/fab_store.sv =====
module fab_store (
    input  logic                                 i_clk,
    input  fab_pkg::t_store_req                  i_req,
    output logic signed [fab_pkg::SAMPLE_W-1:0]  o_base_rd,
    output logic signed [fab_pkg::VAL_W-1:0]     o_sum_rd
);

    logic signed [fab_pkg::SAMPLE_W-1:0] mem_base [fab_pkg::POINTS];
    logic signed [fab_pkg::VAL_W-1:0]    mem_sum  [fab_pkg::POINTS];
    logic signed [fab_pkg::SAMPLE_W-1:0] r_base_rd;
    logic signed [fab_pkg::VAL_W-1:0]    r_sum_rd;

    // Baseline memory, one port, registered read
    always_ff @(posedge i_clk) begin
        if (i_req.base_we) begin
            mem_base[i_req.addr] <= i_req.base_wdata;
        end
        if (i_req.rd_en) begin
            r_base_rd <= mem_base[i_req.addr];
        end
    end

    // Running sum memory, one port, registered read
    always_ff @(posedge i_clk) begin
        if (i_req.sum_we) begin
            mem_sum[i_req.addr] <= i_req.sum_wdata;
        end
        if (i_req.rd_en) begin
            r_sum_rd <= mem_sum[i_req.addr];
        end
    end

    assign o_base_rd = r_base_rd;
    assign o_sum_rd  = r_sum_rd;

endmodule

// ===== src/fab_div.sv =====
module fab_div (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic signed [fab_pkg::VAL_W-1:0]   i_dividend,
    input  logic [fab_pkg::DIVR_W-1:0]         i_divisor,
    output logic                               o_done,
    output logic signed [fab_pkg::VAL_W-1:0]   o_quot
);

    localparam int STEP_W = $clog2(fab_pkg::VAL_W);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(fab_pkg::VAL_W - 1);

    localparam logic [1:0] P_IDLE = 2'd0;
    localparam logic [1:0] P_ABS  = 2'd1;
    localparam logic [1:0] P_RUN  = 2'd2;
    localparam logic [1:0] P_FIX  = 2'd3;

    logic [1:0]                    r_phase;
    logic [STEP_W-1:0]             r_cnt;
    logic                          r_done;
    logic                          r_neg;
    logic [fab_pkg::VAL_W-1:0]     r_quo;
    logic [fab_pkg::DIVR_W-1:0]    r_rem;
    logic [fab_pkg::DIVR_W-1:0]    r_dvs;
    logic signed [fab_pkg::VAL_W-1:0] r_quot;

    logic [fab_pkg::DIVR_W:0]      c_shift;
    logic                          c_ge;
    logic [fab_pkg::DIVR_W:0]      c_rem;

    // One restoring step per cycle
    always_comb begin
        c_shift = {r_rem, r_quo[fab_pkg::VAL_W-1]};
        c_ge    = (c_shift >= {1'b0, r_dvs});
        c_rem   = c_ge ? (c_shift - {1'b0, r_dvs}) : c_shift;
    end

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= P_IDLE;
            r_cnt   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_phase)
                P_IDLE: begin
                    if (i_start) begin
                        r_phase <= P_ABS;
                    end
                end
                P_ABS: begin
                    r_cnt   <= '0;
                    r_phase <= P_RUN;
                end
                P_RUN: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == LAST_STEP) begin
                        r_phase <= P_FIX;
                    end
                end
                P_FIX: begin
                    r_done  <= 1'b1;
                    r_phase <= P_IDLE;
                end
                default: r_phase <= P_IDLE;
            endcase
        end
    end

    // Datapath: magnitude, shift-subtract, sign fix
    always_ff @(posedge i_clk) begin
        case (r_phase)
            P_IDLE: begin
                if (i_start) begin
                    r_quo <= i_dividend;
                    r_neg <= i_dividend[fab_pkg::VAL_W-1];
                    r_dvs <= i_divisor;
                end
            end
            P_ABS: begin
                r_quo <= r_neg ? (~r_quo + 1'b1) : r_quo;
                r_rem <= '0;
            end
            P_RUN: begin
                r_rem <= c_rem[fab_pkg::DIVR_W-1:0];
                r_quo <= {r_quo[fab_pkg::VAL_W-2:0], c_ge};
            end
            P_FIX: begin
                r_quot <= r_neg ? -$signed(r_quo) : $signed(r_quo);
            end
            default: ;
        endcase
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

// ===== verif/frame_accumulate_baseline_top_tb.sv =====
`timescale 1ns / 100ps

module frame_accumulate_baseline_top_tb;

    localparam logic [1:0] MODE_ALT_PASS = 2'd3;   // unnamed mode, acts as pass through
    localparam int         DRAIN_CYCLES   = 64;
    localparam int         HOLD_CYCLES    = 250;
    localparam int         WATCHDOG_LIMIT = 5000;
    localparam int         REPORT_LIMIT   = 40;
    localparam longint     SUM_MAX = 64'sd549755813887;
    localparam longint     SUM_MIN = -64'sd549755813888;

    // One input request and one result point
    typedef struct packed {
        logic [fab_pkg::FUNC_W-1:0]          func;
        logic [fab_pkg::PIDX_W-1:0]          pidx;
        logic [fab_pkg::X_W-1:0]             x;
        logic signed [fab_pkg::SAMPLE_W-1:0] sval;
        logic                                last;
    } t_point_req;

    typedef struct packed {
        logic [fab_pkg::PIDX_W-1:0]       index;
        logic [fab_pkg::X_W-1:0]          x;
        logic signed [fab_pkg::VAL_W-1:0] value;
        logic                             last;
    } t_point_res;

    // Frame averaging predictor plus the queue of expected points
    class frame_avg_scoreboard;
        longint                              sum_mem[fab_pkg::POINTS];
        bit                                  sum_written[fab_pkg::POINTS];
        logic signed [fab_pkg::SAMPLE_W-1:0] base_mem[fab_pkg::POINTS];
        bit                                  base_written[fab_pkg::POINTS];
        bit                                  base_valid;
        int unsigned                         frames_done;
        bit                                  sums_fresh;
        logic [1:0]                          mode;
        int unsigned                         target;
        bit                                  div_en;
        t_point_res                          expected_points[$];
        int                                  errors;

        function new();
            base_valid  = 1'b0;
            frames_done = 0;
            sums_fresh  = 1'b1;
            mode        = fab_pkg::MODE_PASS;
            target      = 0;
            div_en      = 1'b0;
            errors      = 0;
        endfunction

        function void restart_accumulation();
            frames_done = 0;
            sums_fresh  = 1'b1;
        endfunction

        function void write_reg(logic [1:0] reg_idx, logic [fab_pkg::PDATA_W-1:0] value);
            case (reg_idx)
                fab_pkg::REG_MODE: begin
                    // entering accumulate mode starts the sums over
                    if (value[1:0] == fab_pkg::MODE_ACC && mode != fab_pkg::MODE_ACC)
                        restart_accumulation();
                    mode = value[1:0];
                end
                fab_pkg::REG_TARGET: target = 32'(value[fab_pkg::CNT_W-1:0]);
                fab_pkg::REG_DIV_EN: div_en = value[0];
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_points.size();
        endfunction

        // Any point whose running sum has been written
        function logic [fab_pkg::PIDX_W-1:0] some_written_point();
            int start;
            int k;
            start = $urandom_range(0, fab_pkg::POINTS - 1);
            for (int i = 0; i < fab_pkg::POINTS; i++) begin
                k = (start + i) % fab_pkg::POINTS;
                if (sum_written[k])
                    return fab_pkg::PIDX_W'(k);
            end
            return '0;
        endfunction

        // Update state for an accepted request, queue the point it yields
        function void note_request(t_point_req r);
            int          idx;
            longint      base;
            longint      prev;
            longint      s;
            longint      val;
            int unsigned cur;
            t_point_res  exp_pt;
            idx = int'(r.pidx) % fab_pkg::POINTS;
            case (r.func)
                fab_pkg::FUNC_LOAD: begin
                    base_mem[idx]     = r.sval;
                    base_written[idx] = 1'b1;
                    base_valid        = 1'b1;
                    return;
                end
                fab_pkg::FUNC_CLEAR: begin
                    base_valid = 1'b0;
                    return;
                end
                fab_pkg::FUNC_RESTART: begin
                    restart_accumulation();
                    return;
                end
                default: ;
            endcase

            base = base_valid ? longint'($signed(base_mem[idx])) : 0;
            if (mode == fab_pkg::MODE_ACC) begin
                prev = sums_fresh ? 0 : sum_mem[idx];
                s = prev + (longint'($signed(r.sval)) - base);
                if (s > SUM_MAX) s = SUM_MAX;
                if (s < SUM_MIN) s = SUM_MIN;
                sum_mem[idx]     = s;
                sum_written[idx] = 1'b1;
                cur = frames_done + 1;
                if (target == 0) begin
                    // running sums every frame
                    if (r.last) begin
                        frames_done = (cur > 65535) ? 65535 : cur;
                        sums_fresh  = 1'b0;
                    end
                    val = s;
                end else if (cur >= target) begin
                    // completing frame: emit, then start over
                    val = div_en ? s / longint'(cur) : s;
                    if (r.last)
                        restart_accumulation();
                end else begin
                    if (r.last) begin
                        frames_done = cur;
                        sums_fresh  = 1'b0;
                    end
                    return;
                end
            end else if (mode == fab_pkg::MODE_BASE) begin
                val = longint'($signed(r.sval)) - base;
            end else begin
                val = longint'($signed(r.sval));
            end
            exp_pt.index = r.pidx;
            exp_pt.x     = r.x;
            exp_pt.value = val[fab_pkg::VAL_W-1:0];
            exp_pt.last  = r.last;
            expected_points.push_back(exp_pt);
        endfunction

        task report_mismatch(string msg);
            if (errors < REPORT_LIMIT)
                $display("[%0t] mismatch: %s", $realtime, msg);
            errors++;
        endtask

        task check_result(t_point_res got);
            t_point_res exp_pt;
            if (expected_points.size() == 0) begin
                report_mismatch($sformatf("unexpected point index %0d value %0d",
                                          got.index, got.value));
                return;
            end
            exp_pt = expected_points.pop_front();
            if (got.index !== exp_pt.index)
                report_mismatch($sformatf("index got %0d exp %0d", got.index, exp_pt.index));
            if (got.x !== exp_pt.x)
                report_mismatch($sformatf("x got %0d exp %0d", got.x, exp_pt.x));
            if (got.value !== exp_pt.value)
                report_mismatch($sformatf("value got %0d exp %0d (index %0d)",
                                          got.value, exp_pt.value, exp_pt.index));
            if (got.last !== exp_pt.last)
                report_mismatch($sformatf("last got %0b exp %0b", got.last, exp_pt.last));
        endtask
    endclass

    // DUT signals
    logic                                i_clk          = 1'b0;
    logic                                i_rst_n        = 1'b0;
    logic                                i_in_valid     = 1'b0;
    logic                                o_in_ready;
    logic [fab_pkg::FUNC_W-1:0]          i_func         = fab_pkg::FUNC_SAMPLE;
    logic [fab_pkg::PIDX_W-1:0]          i_point_index  = '0;
    logic [fab_pkg::X_W-1:0]             i_x_coord      = '0;
    logic signed [fab_pkg::SAMPLE_W-1:0] i_sample_value = '0;
    logic                                i_frame_last   = 1'b0;
    logic                                o_out_valid;
    logic                                i_out_ready    = 1'b0;
    logic [fab_pkg::PIDX_W-1:0]          o_out_index;
    logic [fab_pkg::X_W-1:0]             o_out_x;
    logic signed [fab_pkg::VAL_W-1:0]    o_out_value;
    logic                                o_out_last;
    logic                                psel           = 1'b0;
    logic                                penable        = 1'b0;
    logic                                pwrite         = 1'b0;
    logic [fab_pkg::PADDR_W-1:0]         paddr          = '0;
    logic [fab_pkg::PDATA_W-1:0]         pwdata         = '0;
    logic [fab_pkg::PDATA_W-1:0]         prdata;
    logic                                pready;

    frame_avg_scoreboard sb = new();
    int items_sent   = 0;
    int sender_calm  = 0;
    bit hold_request = 1'b0;

    frame_accumulate_baseline_top dut (.*);

    always #2 i_clk = ~i_clk;

    // Idle length: mostly none or short, a few long, with calm stretches
    function automatic int draw_idle(inout int calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 149) == 0) begin
            calm = $urandom_range(40, 200);
            return 0;
        end
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: return 0;
            9:             return $urandom_range(8, 40);
            default:       return $urandom_range(1, 3);
        endcase
    endfunction

    function automatic logic signed [fab_pkg::SAMPLE_W-1:0] rand_value();
        case ($urandom_range(0, 9))
            0:       return 16'sh8000;
            1:       return 16'sh7FFF;
            2:       return fab_pkg::SAMPLE_W'($urandom_range(0, 16) - 8);
            default: return fab_pkg::SAMPLE_W'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic logic [fab_pkg::PIDX_W-1:0] rand_index();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return fab_pkg::PIDX_W'($urandom_range(0, fab_pkg::POINTS - 1));
        endcase
    endfunction

    function automatic logic [fab_pkg::X_W-1:0] rand_x();
        return fab_pkg::X_W'($urandom_range(0, 65535));
    endfunction

    // Offer one request and hold it until accepted; valid stays high if
    // no gap follows, so the caller must send again or idle the channel
    task automatic send_request(input logic [fab_pkg::FUNC_W-1:0] func,
                                input logic [fab_pkg::PIDX_W-1:0] pidx,
                                input logic [fab_pkg::X_W-1:0] x,
                                input logic signed [fab_pkg::SAMPLE_W-1:0] sval,
                                input logic last);
        t_point_req r;
        int         gap;
        r = '{func: func, pidx: pidx, x: x, sval: sval, last: last};
        i_in_valid     <= 1'b1;
        i_func         <= func;
        i_point_index  <= pidx;
        i_x_coord      <= x;
        i_sample_value <= sval;
        i_frame_last   <= last;
        do @(posedge i_clk); while (!(i_in_valid && o_in_ready));
        sb.note_request(r);
        items_sent++;
        gap = draw_idle(sender_calm);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Sample request that never reads a store entry that was not written
    task automatic send_sample(input logic [fab_pkg::PIDX_W-1:0] pidx,
                               input logic [fab_pkg::X_W-1:0] x,
                               input logic signed [fab_pkg::SAMPLE_W-1:0] sval,
                               input logic last);
        logic [fab_pkg::PIDX_W-1:0] p;
        p = pidx;
        if (sb.mode == fab_pkg::MODE_ACC && !sb.sums_fresh && !sb.sum_written[p])
            p = sb.some_written_point();
        if (sb.base_valid && !sb.base_written[p])
            send_request(fab_pkg::FUNC_LOAD, p, rand_x(), rand_value(),
                         1'($urandom_range(0, 1)));
        send_request(fab_pkg::FUNC_SAMPLE, p, x, sval, last);
    endtask

    // Stray control or sample request inside a frame
    task automatic send_noise();
        case ($urandom_range(0, 4))
            0: send_request(fab_pkg::FUNC_LOAD, rand_index(), rand_x(), rand_value(),
                            1'($urandom_range(0, 1)));
            1: send_request(fab_pkg::FUNC_CLEAR, rand_index(), rand_x(), rand_value(),
                            1'($urandom_range(0, 1)));
            2: send_request(fab_pkg::FUNC_RESTART, rand_index(), rand_x(), rand_value(),
                            1'($urandom_range(0, 1)));
            default: send_sample(rand_index(), rand_x(), rand_value(), 1'($urandom_range(0, 1)));
        endcase
    endtask

    task automatic idle_input();
        i_in_valid <= 1'b0;
    endtask

    // Wait for every expected point, then for requests without a result to drain
    task automatic quiesce();
        idle_input();
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [1:0] reg_idx,
                                  input logic [fab_pkg::PDATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= fab_pkg::PADDR_W'({reg_idx, 2'b00});
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.write_reg(reg_idx, value);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic apply_setting(input logic [1:0] mode, input int target, input bit div);
        quiesce();
        write_register(fab_pkg::REG_MODE, fab_pkg::PDATA_W'(mode));
        write_register(fab_pkg::REG_TARGET, fab_pkg::PDATA_W'(target));
        write_register(fab_pkg::REG_DIV_EN, fab_pkg::PDATA_W'(div));
    endtask

    // Field extremes, every request kind and the corner cases
    task automatic run_directed();
        apply_setting(fab_pkg::MODE_PASS, 0, 0);
        send_sample(10'd0, 16'h0000, 16'sh8000, 1'b0);
        send_sample(10'd1023, 16'hFFFF, 16'sh7FFF, 1'b1);
        send_request(fab_pkg::FUNC_LOAD, 10'd1023, 16'h0000, 16'sh7FFF, 1'b0);
        send_request(fab_pkg::FUNC_LOAD, 10'd0, 16'hFFFF, 16'sh8000, 1'b1);
        send_sample(10'd0, 16'h5555, 16'sd100, 1'b1);      // pass ignores baseline

        // deduction at both extremes, then with the baseline cleared
        apply_setting(fab_pkg::MODE_BASE, 0, 0);
        send_sample(10'd0, 16'hAAAA, 16'sh7FFF, 1'b0);
        send_sample(10'd1023, 16'h0001, 16'sh8000, 1'b1);
        send_request(fab_pkg::FUNC_CLEAR, 10'd0, 16'h0000, 16'sh0000, 1'b0);
        send_sample(10'd5, 16'h0002, 16'sd77, 1'b1);

        // running sums; point repeated in the first frame starts from zero
        apply_setting(fab_pkg::MODE_ACC, 0, 0);
        send_sample(10'd0, 16'h0003, 16'sd10, 1'b0);
        send_sample(10'd0, 16'h0004, 16'sd20, 1'b0);
        send_sample(10'd1023, 16'h0005, -16'sd1, 1'b1);
        send_sample(10'd0, 16'h0006, 16'sd5, 1'b0);
        send_sample(10'd1023, 16'h0007, 16'sh8000, 1'b1);
        send_request(fab_pkg::FUNC_RESTART, 10'd0, 16'h0000, 16'sh0000, 1'b0);
        send_sample(10'd0, 16'h0008, 16'sd1, 1'b1);

        apply_setting(MODE_ALT_PASS, 0, 0);
        send_sample(10'd512, 16'h0009, -16'sd5, 1'b1);

        // two-frame average of a negative sum truncates toward zero
        apply_setting(fab_pkg::MODE_ACC, 2, 1);
        send_sample(10'd0, 16'h000A, -16'sd7, 1'b1);
        send_sample(10'd0, 16'h000B, 16'sd0, 1'b1);
    endtask

    // Well-formed frames with random content, plus stray and cut-short requests
    task automatic run_phase(input logic [1:0] mode, input int target, input bit div,
                             input int budget);
        int                         first;
        int                         n;
        bit                         cut;
        logic [fab_pkg::PIDX_W-1:0] pts[$];
        apply_setting(mode, target, div);
        if (mode == fab_pkg::MODE_BASE)
            send_request(fab_pkg::FUNC_LOAD, rand_index(), rand_x(), rand_value(), 1'b0);
        first = items_sent;
        while (items_sent - first < budget) begin
            // new point set only where the sums allow it
            if (pts.size() == 0 ||
                ((sb.mode != fab_pkg::MODE_ACC || sb.sums_fresh) &&
                 $urandom_range(0, 1) == 0)) begin
                pts.delete();
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 24) : $urandom_range(1, 5);
                repeat (n) begin
                    if (pts.size() > 0 && $urandom_range(0, 9) == 0)
                        pts.push_back(pts[$]);
                    else
                        pts.push_back(rand_index());
                end
            end
            foreach (pts[j]) begin
                if ($urandom_range(0, 19) == 0)
                    send_noise();
                cut = (j < pts.size() - 1) && ($urandom_range(0, 39) == 0);
                send_sample(pts[j], rand_x(), rand_value(), (j == pts.size() - 1) || cut);
                if (cut)
                    break;
            end
        end
    endtask

    // Result side: random stalls, one long hold-off on request
    initial begin : result_sink
        int         low_left;
        int         calm;
        t_point_res got;
        low_left = 0;
        calm     = 0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(posedge i_clk);
            if (o_out_valid && i_out_ready) begin
                got.index = o_out_index;
                got.x     = o_out_x;
                got.value = o_out_value;
                got.last  = o_out_last;
                sb.check_result(got);
            end
            if (hold_request) begin
                hold_request = 1'b0;
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else if (low_left > 0) begin
                i_out_ready <= 1'b0;
                low_left--;
            end else begin
                i_out_ready <= 1'b1;
                low_left = draw_idle(calm);
            end
        end
    end

    // Ends the run when nothing moves for too long
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || psel || !i_rst_n)
                quiet = 0;
            else
                quiet++;
        end
        $display("frame_accumulate_baseline_top regression: fail");
        $finish;
    end

    initial begin : stimulus
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        run_directed();

        // first phase also fills the block while the result side holds off
        apply_setting(fab_pkg::MODE_PASS, 0, 0);
        hold_request = 1'b1;
        run_phase(fab_pkg::MODE_PASS, 0, 0, 150);
        run_phase(fab_pkg::MODE_BASE, 0, 0, 150);
        run_phase(fab_pkg::MODE_ACC, 0, 0, 150);
        run_phase(fab_pkg::MODE_ACC, 1, 1, 100);
        run_phase(fab_pkg::MODE_ACC, 3, 0, 130);
        run_phase(MODE_ALT_PASS, 3, 1, 80);
        run_phase(fab_pkg::MODE_ACC, 4, 1, 150);
        run_phase(fab_pkg::MODE_BASE, 65535, 1, 80);
        run_phase(fab_pkg::MODE_ACC, 65535, 0, 60);
        run_phase(fab_pkg::MODE_ACC, 2, 1, 150);
        run_phase(fab_pkg::MODE_ACC, 0, 1, 100);

        quiesce();
        if (sb.errors == 0)
            $display("frame_accumulate_baseline_top regression: pass");
        else
            $display("frame_accumulate_baseline_top regression: fail");
        $finish;
    end

endmodule
